[rtl/sli_pkg.sv]
package sli_pkg;

  // command codes carried in the input transaction
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SHOW   = 1'b1;

  // status codes of a result transaction
  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_DROPPED  = 2'd1;
  localparam logic [1:0] ST_ELEMENT  = 2'd2;
  localparam logic [1:0] ST_END      = 2'd3;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] value;
  } in_t;

  typedef struct packed {
    logic signed [31:0] item;
    logic [1:0]         status;
    logic               last;
  } out_t;

  // controller to datapath commands
  typedef struct packed {
    logic latch;      // capture the accepted request
    logic insert;     // insert or drop, load status result
    logic show_clr;   // reset the show index
    logic emit_elem;  // load the element at the show index
    logic emit_end;   // load the end-of-list marker
  } ctl_t;

  // datapath to controller status
  typedef struct packed {
    logic req_show;   // latched request is a show
    logic slot_free;  // output register can take a result
    logic at_end;     // show index reached the entry count
  } sts_t;

endpackage

[rtl/sli_datapath.sv]
module sli_datapath import sli_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  input  ctl_t ctl,
  output sts_t sts,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int CntW = $clog2(CAPACITY + 1);
  localparam int IdxW = $clog2(CAPACITY);

  in_t                req;
  logic signed [31:0] cells [CAPACITY];
  logic [CntW-1:0]    count;
  logic [CntW-1:0]    idx;

  logic               full;
  logic [CAPACITY-1:0] lt;
  logic signed [31:0] cells_next [CAPACITY];
  logic signed [31:0] elem;

  assign full = (count == CntW'(CAPACITY));

  // per-cell compare against the new value, valid cells only
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lt[i] = (CntW'(i) < count) && (cells[i] < req.value);
    end
  end

  // every cell keeps, takes the new value, or takes its left neighbor
  always_comb begin
    cells_next[0] = lt[0] ? cells[0] : req.value;
    for (int i = 1; i < CAPACITY; i++) begin
      if (lt[i]) begin
        cells_next[i] = cells[i];
      end else if (lt[i-1]) begin
        cells_next[i] = req.value;
      end else begin
        cells_next[i] = cells[i-1];
      end
    end
  end

  assign elem = cells[idx[IdxW-1:0]];

  assign sts.req_show  = (req.cmd == CMD_SHOW);
  assign sts.slot_free = !out_valid || out_ready;
  assign sts.at_end    = (idx == count);

  // request capture
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      req <= in_data;
    end
  end

  // cell row update
  always_ff @(posedge clk) begin
    if (ctl.insert && !full) begin
      for (int i = 0; i < CAPACITY; i++) begin
        cells[i] <= cells_next[i];
      end
    end
  end

  // entry count and show index
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
    end else begin
      if (ctl.insert && !full) begin
        count <= count + CntW'(1);
      end
      if (ctl.show_clr) begin
        idx <= '0;
      end else if (ctl.emit_elem) begin
        idx <= idx + CntW'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.insert || ctl.emit_elem || ctl.emit_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.insert) begin
      out_data.item   <= full ? 32'sd0 : req.value;
      out_data.status <= full ? ST_DROPPED : ST_INSERTED;
      out_data.last   <= 1'b1;
    end else if (ctl.emit_elem) begin
      out_data.item   <= elem;
      out_data.status <= ST_ELEMENT;
      out_data.last   <= 1'b0;
    end else if (ctl.emit_end) begin
      out_data.item   <= 32'sd0;
      out_data.status <= ST_END;
      out_data.last   <= 1'b1;
    end
  end

endmodule

[rtl/sli_ctrl.sv]
module sli_ctrl import sli_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output ctl_t ctl
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INS  = 3'b010,
    S_SHOW = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // command decode and next state
  always_comb begin
    state_next    = state;
    ctl           = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.latch    = 1'b1;
          ctl.show_clr = 1'b1;
          state_next   = S_INS;
        end
      end
      S_INS: begin
        if (sts.req_show) begin
          state_next = S_SHOW;
        end else if (sts.slot_free) begin
          ctl.insert = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SHOW: begin
        if (sts.slot_free) begin
          if (sts.at_end) begin
            ctl.emit_end = 1'b1;
            state_next   = S_IDLE;
          end else begin
            ctl.emit_elem = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/sorted_list_insert_and_dump_top.sv]
// insert: the accepted transaction is captured in the request register, then its result
// is loaded into the output register once that is free; no new transaction is accepted before then
// show of n entries: n + 1 results, one per cycle while the output register can take one
// results wait while the output register holds data that the consumer has not taken
// reset clears the entry count, the controller and the output valid; cell contents are kept
module sorted_list_insert_and_dump_top import sli_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  ctl_t ctl;
  sts_t sts;

  // sequencer
  sli_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  // cell row, counters and output register
  sli_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
